// ===== rtl/msgid_pkg.sv =====
// ============================================================================
// msgid_pkg
// Shared types, constants and reset value of the Message-ID syntax checker.
// ============================================================================
`default_nettype none

package msgid_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int POS_W      = $clog2(MAX_LENGTH + 1);
    localparam int LEN_W      = 11;
    localparam int STATUS_W   = 3;
    localparam int MIN_LENGTH = 5;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ANGLE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_UTF8 = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_AT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_PART = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd5;

    localparam logic [1:0] PH_LEAD        = 2'd0;
    localparam logic [1:0] PH_NOT_BRACKET = 2'd1;
    localparam logic [1:0] PH_INSIDE      = 2'd2;
    localparam logic [1:0] PH_TOO_LONG    = 2'd3;

    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_RBR  = 8'h5D;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;

    typedef struct packed {
        logic after_dot;
        logic bad;
    } atom_t;

    typedef struct packed {
        logic started;
        logic escape;
        logic close_cand;
        logic bad;
    } lit_t;

    typedef struct packed {
        logic             at_seen;
        logic [POS_W-1:0] at_pos;
        logic [POS_W-1:0] count;
        atom_t            left;
        atom_t            right;
        lit_t             lit;
        logic [1:0]       u8_rem;
        logic [2:0]       u8_range;
        logic             u8_bad;
    } ins_t;

    typedef struct packed {
        logic [1:0]       phase;
        logic [POS_W-1:0] byte_pos;
        logic [POS_W-1:0] open_pos;
        logic             pend_gt;
        logic [1:0]       pend_ws;
        ins_t             ins;
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    source_start;
        logic [LEN_W-1:0]    source_length;
        logic [LEN_W-1:0]    left_length;
        logic [LEN_W-1:0]    right_length;
        logic                right_is_literal;
    } result_t;

    function automatic state_t state_reset();
        state_t s;
        s                    = '0;
        s.phase              = PH_LEAD;
        s.ins.left.after_dot = 1'b1;
        s.ins.right.after_dot = 1'b1;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/msgid_inside.sv =====
// ============================================================================
// msgid_inside
// One byte between the brackets: UTF-8, at-sign split, atom and literal checks.
// ============================================================================
`default_nettype none

module msgid_inside (
    input  wire logic          en,
    input  wire logic [7:0]    text_byte,
    input  wire logic          utf8_mode,
    input  wire msgid_pkg::ins_t cur,
    output msgid_pkg::ins_t    nxt
);
    import msgid_pkg::*;

    localparam logic [2:0] RG_FULL = 3'd0;
    localparam logic [2:0] RG_E0   = 3'd1;
    localparam logic [2:0] RG_ED   = 3'd2;
    localparam logic [2:0] RG_F0   = 3'd3;
    localparam logic [2:0] RG_F4   = 3'd4;

    function automatic logic is_atext(logic [7:0] b);
        return b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
                         8'h2B, 8'h2D, 8'h2F, 8'h3D, 8'h3F, 8'h5E, 8'h5F,
                         8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E};
    endfunction

    function automatic atom_t atom_step(atom_t a, logic [7:0] b, logic mode);
        atom_t r;
        r = a;
        if (b == CH_DOT)
        begin
            if (a.after_dot)
                r.bad = 1'b1;
            r.after_dot = 1'b1;
        end
        else
        begin
            if (b[7] ? !mode : !is_atext(b))
                r.bad = 1'b1;
            r.after_dot = 1'b0;
        end
        return r;
    endfunction

    function automatic lit_t lit_step(lit_t l, logic [7:0] b, logic mode, logic first);
        lit_t r;
        r = l;
        if (first)
        begin
            r.started = (b == CH_LBR);
        end
        else
        begin
            if (r.close_cand)
            begin
                r.bad        = 1'b1;
                r.close_cand = 1'b0;
            end
            if (r.escape)
                r.escape = 1'b0;
            else if (b == CH_BSL)
                r.escape = 1'b1;
            else if (b == CH_RBR)
                r.close_cand = 1'b1;
            else if (b == CH_LBR || b < 8'd33 || (b > 8'd126 && !mode))
                r.bad = 1'b1;
        end
        return r;
    endfunction

    logic           first;
    logic [7:0]     lo;
    logic [7:0]     hi;

    assign first = ({1'b0, cur.count} == ({1'b0, cur.at_pos} + (POS_W+1)'(1)));

    always_comb
    begin
        lo = 8'h80;
        hi = 8'hBF;
        case (cur.u8_range)
            RG_E0:   lo = 8'hA0;
            RG_ED:   hi = 8'h9F;
            RG_F0:   lo = 8'h90;
            RG_F4:   hi = 8'h8F;
            default: ;
        endcase
    end

    always_comb
    begin
        nxt = cur;
        if (en)
        begin
            // UTF-8 decoder
            if (cur.u8_rem != 2'd0)
            begin
                if (text_byte < lo || text_byte > hi)
                begin
                    nxt.u8_bad = 1'b1;
                    nxt.u8_rem = 2'd0;
                end
                else
                begin
                    nxt.u8_rem = cur.u8_rem - 2'd1;
                end
                nxt.u8_range = RG_FULL;
            end
            else if (text_byte[7])
            begin
                if (text_byte inside {[8'hC2:8'hDF]})
                    nxt.u8_rem = 2'd1;
                else if (text_byte == 8'hE0)
                begin
                    nxt.u8_rem   = 2'd2;
                    nxt.u8_range = RG_E0;
                end
                else if (text_byte == 8'hED)
                begin
                    nxt.u8_rem   = 2'd2;
                    nxt.u8_range = RG_ED;
                end
                else if (text_byte inside {[8'hE1:8'hEF]})
                    nxt.u8_rem = 2'd2;
                else if (text_byte == 8'hF0)
                begin
                    nxt.u8_rem   = 2'd3;
                    nxt.u8_range = RG_F0;
                end
                else if (text_byte == 8'hF4)
                begin
                    nxt.u8_rem   = 2'd3;
                    nxt.u8_range = RG_F4;
                end
                else if (text_byte inside {[8'hF1:8'hF3]})
                    nxt.u8_rem = 2'd3;
                else
                    nxt.u8_bad = 1'b1;
            end

            // split at first at sign
            if (!cur.at_seen)
            begin
                if (text_byte == CH_AT)
                begin
                    nxt.at_seen = 1'b1;
                    nxt.at_pos  = cur.count;
                end
                else
                begin
                    nxt.left = atom_step(cur.left, text_byte, utf8_mode);
                end
            end
            else
            begin
                nxt.right = atom_step(cur.right, text_byte, utf8_mode);
                nxt.lit   = lit_step(cur.lit, text_byte, utf8_mode, first);
            end
            nxt.count = cur.count + POS_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/msgid_scan.sv =====
// ============================================================================
// msgid_scan
// Next state and final result for one byte of the header value.
// ============================================================================
`default_nettype none

module msgid_scan (
    input  wire msgid_pkg::state_t cur,
    input  wire logic              utf8_mode,
    input  wire logic [7:0]        text_byte,
    input  wire logic              is_last,
    output msgid_pkg::state_t      state_next,
    output msgid_pkg::result_t     res
);
    import msgid_pkg::*;

    logic         ws;
    logic         too_long_now;
    logic [1:0]   phase_upd;
    logic         feeding;
    logic         en_gt;
    logic         en_ws0;
    logic         en_ws1;
    logic         en_byte;
    ins_t         ins0;
    ins_t         ins1;
    ins_t         ins2;
    ins_t         ins3;
    ins_t         ins4;
    state_t       upd;
    logic [POS_W-1:0] right_len;
    logic [POS_W:0]   total_len;
    logic         left_ok;
    logic         right_atom_ok;
    logic         lit_ok;
    logic [STATUS_W-1:0] status;

    assign ws           = (text_byte == CH_SP) || (text_byte == CH_TAB);
    assign too_long_now = (cur.byte_pos >= POS_W'(MAX_LENGTH));

    always_comb
    begin
        phase_upd = too_long_now ? PH_TOO_LONG : cur.phase;
    end

    assign feeding = (phase_upd == PH_INSIDE) && (cur.phase == PH_INSIDE) && !ws;
    assign en_gt   = feeding && cur.pend_gt;
    assign en_ws0  = feeding && (cur.pend_ws != 2'd0);
    assign en_ws1  = feeding && (cur.pend_ws == 2'd2);
    assign en_byte = feeding && (text_byte != CH_GT);

    assign ins0 = cur.ins;

    msgid_inside u_ins_gt (
        .en        (en_gt),
        .text_byte (CH_GT),
        .utf8_mode (utf8_mode),
        .cur       (ins0),
        .nxt       (ins1)
    );

    msgid_inside u_ins_ws0 (
        .en        (en_ws0),
        .text_byte (CH_SP),
        .utf8_mode (utf8_mode),
        .cur       (ins1),
        .nxt       (ins2)
    );

    msgid_inside u_ins_ws1 (
        .en        (en_ws1),
        .text_byte (CH_SP),
        .utf8_mode (utf8_mode),
        .cur       (ins2),
        .nxt       (ins3)
    );

    msgid_inside u_ins_byte (
        .en        (en_byte),
        .text_byte (text_byte),
        .utf8_mode (utf8_mode),
        .cur       (ins3),
        .nxt       (ins4)
    );

    always_comb
    begin
        upd          = cur;
        upd.phase    = phase_upd;
        upd.ins      = ins4;
        if (!too_long_now)
            upd.byte_pos = cur.byte_pos + POS_W'(1);
        if (phase_upd == PH_LEAD)
        begin
            if (!ws)
            begin
                if (text_byte == CH_LT)
                begin
                    upd.phase    = PH_INSIDE;
                    upd.open_pos = cur.byte_pos;
                end
                else
                begin
                    upd.phase = PH_NOT_BRACKET;
                end
            end
        end
        else if (phase_upd == PH_INSIDE)
        begin
            if (ws)
            begin
                if (cur.pend_ws != 2'd2)
                    upd.pend_ws = cur.pend_ws + 2'd1;
            end
            else
            begin
                upd.pend_gt = (text_byte == CH_GT);
                upd.pend_ws = 2'd0;
            end
        end
    end

    assign right_len     = upd.ins.at_seen ? (upd.ins.count - upd.ins.at_pos - POS_W'(1))
                                           : '0;
    assign total_len     = {1'b0, upd.ins.count} + (POS_W+1)'(2);
    assign left_ok       = !upd.ins.left.bad && !upd.ins.left.after_dot;
    assign right_atom_ok = !upd.ins.right.bad && !upd.ins.right.after_dot;
    assign lit_ok        = upd.ins.lit.started && !upd.ins.lit.bad &&
                           upd.ins.lit.close_cand && (right_len >= POS_W'(3));

    always_comb
    begin
        if (upd.phase == PH_TOO_LONG)
            status = ST_TOO_LONG;
        else if (upd.phase != PH_INSIDE || !upd.pend_gt ||
                 total_len < (POS_W+1)'(MIN_LENGTH))
            status = ST_NO_ANGLE;
        else if (utf8_mode && (upd.ins.u8_bad || upd.ins.u8_rem != 2'd0))
            status = ST_BAD_UTF8;
        else if (!upd.ins.at_seen)
            status = ST_NO_AT;
        else if (!left_ok || !(right_atom_ok || lit_ok))
            status = ST_BAD_PART;
        else
            status = ST_OK;
    end

    always_comb
    begin
        res        = '0;
        res.status = status;
        if (status == ST_OK)
        begin
            res.source_start     = LEN_W'(upd.open_pos);
            res.source_length    = LEN_W'(total_len);
            res.left_length      = LEN_W'(upd.ins.at_pos);
            res.right_length     = LEN_W'(right_len);
            res.right_is_literal = !right_atom_ok && lit_ok;
        end
    end

    assign state_next = is_last ? state_reset() : upd;

endmodule

`default_nettype wire

// ===== rtl/message_id_syntax_checker_core.sv =====
// ============================================================================
// message_id_syntax_checker_core
// Byte-serial Message-ID syntax checker with status, offsets and lengths.
// ============================================================================
// Throughput: one byte per cycle, no bubbles while the result side takes items.
// Result path: an accepted last byte is held in the input register, and its
//   result item is then captured in the result register.
// Reset: asynchronous, clears stream state, valid flags and utf8_mode.
// Stream state also returns to its reset value after every last byte.
`default_nettype none

module message_id_syntax_checker_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write_en,
    input  wire logic                            cfg_write_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      text_byte,
    input  wire logic                            is_last,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [msgid_pkg::STATUS_W-1:0]       status,
    output logic [msgid_pkg::LEN_W-1:0]          source_start,
    output logic [msgid_pkg::LEN_W-1:0]          source_length,
    output logic [msgid_pkg::LEN_W-1:0]          left_length,
    output logic [msgid_pkg::LEN_W-1:0]          right_length,
    output logic                                 right_is_literal
);
    import msgid_pkg::*;

    logic        utf8_mode_reg;
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    state_t      state_reg;
    state_t      state_next;
    result_t     res_next;
    result_t     res_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        in_take;

    assign advance  = in_valid_reg && !(last_reg && out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            utf8_mode_reg <= 1'b0;
        else if (cfg_write_en)
            utf8_mode_reg <= cfg_write_data;
    end

    // hold byte in input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= text_byte;
            last_reg <= is_last;
        end
    end

    msgid_scan u_scan (
        .cur        (state_reg),
        .utf8_mode  (utf8_mode_reg),
        .text_byte  (byte_reg),
        .is_last    (last_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= state_reset();
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && last_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
            res_reg <= res_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = res_reg.status;
    assign source_start     = res_reg.source_start;
    assign source_length    = res_reg.source_length;
    assign left_length      = res_reg.left_length;
    assign right_length     = res_reg.right_length;
    assign right_is_literal = res_reg.right_is_literal;

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.byte_pos <= POS_W'(MAX_LENGTH))
        else $error("byte position past maximum");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> state_reg.phase == PH_LEAD &&
                                state_reg.byte_pos == '0 && out_valid_reg)
        else $error("stream state not cleared after last byte");

    a_ok_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.status == ST_OK |->
            res_reg.source_length >= LEN_W'(MIN_LENGTH))
        else $error("ok result shorter than minimum");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.status != ST_OK |->
            res_reg.source_length == '0 && res_reg.left_length == '0 &&
            res_reg.right_is_literal == 1'b0)
        else $error("error result carries lengths");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && last_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ===== bench/tb_message_id_syntax_checker_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_message_id_syntax_checker_core
// Streams header values byte by byte into the Message-ID checker. A built-in
// predictor computes the status, offsets and lengths for each final byte, and
// the monitor compares every result item against them. Sender gaps, receiver
// stalls and both utf8_mode settings are exercised.
// ============================================================================

module tb_message_id_syntax_checker_core;

    import msgid_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 6;
    localparam logic [7:0]  PRINT_LO    = 8'd33;
    localparam logic [7:0]  PRINT_HI    = 8'd126;
    localparam logic [7:0]  ASCII_TOP   = 8'h80;
    localparam string       ATEXT       =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!#$%&'*+-/=?^_{|}~";

    typedef enum logic [2:0] {U8_ANY, U8_E0, U8_ED, U8_F0, U8_F4} u8_range_t;
    typedef enum logic [1:0] {PACE_RX_HEAVY, PACE_TX_HEAVY, PACE_FREE} pace_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } stim_t;

    typedef struct {
        bit dot;
        bit bad;
    } pred_atom_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                cfg_write_en   = 1'b0;
    logic                cfg_write_data = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [7:0]          text_byte      = 8'h00;
    logic                is_last        = 1'b0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    source_start;
    logic [LEN_W-1:0]    source_length;
    logic [LEN_W-1:0]    left_length;
    logic [LEN_W-1:0]    right_length;
    logic                right_is_literal;

    stim_t      byte_queue[$];
    result_t    pending_verdicts[$];
    logic [7:0] id_buf[$];
    pace_t      pace = PACE_RX_HEAVY;

    int error_count   = 0;
    int results_seen  = 0;
    int values_queued = 0;
    int bytes_queued  = 0;
    int cycle_count   = 0;

    // predictor state
    bit          utf8_on;
    logic [1:0]  p_phase;
    int unsigned p_pos;
    int unsigned p_open;
    int unsigned p_at;
    int unsigned p_cnt;
    bit          p_at_seen;
    pred_atom_t  left_atom;
    pred_atom_t  right_atom;
    bit          lit_start;
    bit          lit_esc;
    bit          lit_close;
    bit          lit_bad;
    int unsigned u8_left;
    u8_range_t   u8_rng;
    bit          u8_err;
    bit          gt_held;
    int unsigned ws_held;

    message_id_syntax_checker_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .text_byte        (text_byte),
        .is_last          (is_last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .source_start     (source_start),
        .source_length    (source_length),
        .left_length      (left_length),
        .right_length     (right_length),
        .right_is_literal (right_is_literal)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Message-ID predictor
    // ------------------------------------------------------------------
    task automatic reset_stream();
        p_phase    = PH_LEAD;
        p_pos      = 0;
        p_open     = 0;
        p_at       = 0;
        p_cnt      = 0;
        p_at_seen  = 1'b0;
        left_atom  = '{dot: 1'b1, bad: 1'b0};
        right_atom = '{dot: 1'b1, bad: 1'b0};
        lit_start  = 1'b0;
        lit_esc    = 1'b0;
        lit_close  = 1'b0;
        lit_bad    = 1'b0;
        u8_left    = 0;
        u8_rng     = U8_ANY;
        u8_err     = 1'b0;
        gt_held    = 1'b0;
        ws_held    = 0;
    endtask

    function automatic bit is_atext(logic [7:0] b);
        if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9"))
            return 1'b1;
        case (b)
            "!", "#", "$", "%", "&", "'", "*", "+", "-", "/", "=", "?", "^", "_",
            8'h60, "{", "|", "}", "~": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic pred_atom_t atom_next(pred_atom_t a, logic [7:0] b);
        pred_atom_t n;
        n = a;
        if (b == CH_DOT)
        begin
            if (a.dot)
                n.bad = 1'b1;
            n.dot = 1'b1;
            return n;
        end
        if ((b < ASCII_TOP) ? !is_atext(b) : !utf8_on)
            n.bad = 1'b1;
        n.dot = 1'b0;
        return n;
    endfunction

    task automatic literal_next(logic [7:0] b, bit first);
        if (first)
        begin
            lit_start = (b == CH_LBR);
            return;
        end
        if (lit_close)
        begin
            lit_bad   = 1'b1;
            lit_close = 1'b0;
        end
        if (lit_esc)
            lit_esc = 1'b0;
        else if (b == CH_BSL)
            lit_esc = 1'b1;
        else if (b == CH_RBR)
            lit_close = 1'b1;
        else if (b == CH_LBR || b < PRINT_LO || (b > PRINT_HI && !utf8_on))
            lit_bad = 1'b1;
    endtask

    task automatic utf8_next(logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (u8_left > 0)
        begin
            case (u8_rng)
                U8_E0:   lo = 8'hA0;
                U8_ED:   hi = 8'h9F;
                U8_F0:   lo = 8'h90;
                U8_F4:   hi = 8'h8F;
                default: ;
            endcase
            if (b < lo || b > hi)
            begin
                u8_err  = 1'b1;
                u8_left = 0;
            end
            else
                u8_left--;
            u8_rng = U8_ANY;
        end
        else if (b >= ASCII_TOP)
        begin
            if (b >= 8'hC2 && b <= 8'hDF)
                u8_left = 1;
            else if (b == 8'hE0)
            begin
                u8_left = 2;
                u8_rng  = U8_E0;
            end
            else if (b == 8'hED)
            begin
                u8_left = 2;
                u8_rng  = U8_ED;
            end
            else if (b >= 8'hE1 && b <= 8'hEF)
                u8_left = 2;
            else if (b == 8'hF0)
            begin
                u8_left = 3;
                u8_rng  = U8_F0;
            end
            else if (b == 8'hF4)
            begin
                u8_left = 3;
                u8_rng  = U8_F4;
            end
            else if (b >= 8'hF1 && b <= 8'hF3)
                u8_left = 3;
            else
                u8_err = 1'b1;
        end
    endtask

    task automatic feed_inner(logic [7:0] b);
        utf8_next(b);
        if (!p_at_seen)
        begin
            if (b == CH_AT)
            begin
                p_at_seen = 1'b1;
                p_at      = p_cnt;
            end
            else
                left_atom = atom_next(left_atom, b);
        end
        else
        begin
            right_atom = atom_next(right_atom, b);
            literal_next(b, p_cnt == p_at + 1);
        end
        p_cnt++;
    endtask

    task automatic check_msgid_byte(logic [7:0] b, logic last);
        int unsigned   pos;
        int unsigned   rlen;
        bit            ws;
        bit            l_ok;
        bit            r_ok;
        bit            lit_ok;
        logic [STATUS_W-1:0] st;
        result_t       r;
        pos  = p_pos;
        ws   = (b == CH_SP || b == CH_TAB);
        rlen = 0;
        if (pos >= MAX_LENGTH)
            p_phase = PH_TOO_LONG;
        else
            p_pos = pos + 1;
        if (p_phase == PH_LEAD)
        begin
            if (!ws)
            begin
                if (b == CH_LT)
                begin
                    p_phase = PH_INSIDE;
                    p_open  = pos;
                end
                else
                    p_phase = PH_NOT_BRACKET;
            end
        end
        else if (p_phase == PH_INSIDE)
        begin
            if (ws)
            begin
                if (ws_held < 2)
                    ws_held++;
            end
            else
            begin
                if (gt_held)
                    feed_inner(CH_GT);
                repeat (ws_held) feed_inner(CH_SP);
                gt_held = 1'b0;
                ws_held = 0;
                if (b == CH_GT)
                    gt_held = 1'b1;
                else
                    feed_inner(b);
            end
        end
        if (!last)
            return;
        if (p_at_seen)
            rlen = p_cnt - p_at - 1;
        l_ok   = !left_atom.bad && !left_atom.dot;
        r_ok   = !right_atom.bad && !right_atom.dot;
        lit_ok = lit_start && !lit_bad && lit_close && rlen >= 3;
        if (p_phase == PH_TOO_LONG)
            st = ST_TOO_LONG;
        else if (p_phase != PH_INSIDE || !gt_held || p_cnt + 2 < MIN_LENGTH)
            st = ST_NO_ANGLE;
        else if (utf8_on && (u8_err || u8_left != 0))
            st = ST_BAD_UTF8;
        else if (!p_at_seen)
            st = ST_NO_AT;
        else if (!l_ok || !(r_ok || lit_ok))
            st = ST_BAD_PART;
        else
            st = ST_OK;
        r = '0;
        r.status = st;
        if (st == ST_OK)
        begin
            r.source_start     = p_open[LEN_W-1:0];
            r.source_length    = LEN_W'(p_cnt + 2);
            r.left_length      = p_at[LEN_W-1:0];
            r.right_length     = rlen[LEN_W-1:0];
            r.right_is_literal = !r_ok && lit_ok;
        end
        pending_verdicts.push_back(r);
        reset_stream();
    endtask

    initial reset_stream();

    // ------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------
    function automatic bit sender_gap();
        case (pace)
            PACE_RX_HEAVY: return $urandom_range(99) < 24;
            PACE_TX_HEAVY: return $urandom_range(99) < 66;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_busy();
        case (pace)
            PACE_RX_HEAVY: return $urandom_range(99) < 66;
            PACE_TX_HEAVY: return $urandom_range(99) < 24;
            default:       return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive
        stim_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            text_byte <= 8'h00;
            is_last   <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                check_msgid_byte(text_byte, is_last);
            if (!in_valid || !in_stall)
            begin
                if (byte_queue.size() > 0 && !sender_gap())
                begin
                    nxt = byte_queue.pop_front();
                    in_valid  <= 1'b1;
                    text_byte <= nxt.b;
                    is_last   <= nxt.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {status, source_start, source_length, left_length, right_length,
                       right_is_literal};
                results_seen++;
                if (pending_verdicts.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: st=%0d start=%0d len=%0d", got.status,
                                 got.source_start, got.source_length);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (got.status !== want.status
                        || got.source_start !== want.source_start
                        || got.source_length !== want.source_length
                        || got.left_length !== want.left_length
                        || got.right_length !== want.right_length
                        || got.right_is_literal !== want.right_is_literal)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("mismatch: expected st=%0d start=%0d len=%0d left=%0d right=%0d lit=%0b",
                                     want.status, want.source_start, want.source_length,
                                     want.left_length, want.right_length,
                                     want.right_is_literal);
                            $display("          got      st=%0d start=%0d len=%0d left=%0d right=%0d lit=%0b",
                                     got.status, got.source_start, got.source_length,
                                     got.left_length, got.right_length,
                                     got.right_is_literal);
                        end
                    end
                end
            end
            out_stall <= receiver_busy();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_b(logic [7:0] b);
        id_buf.push_back(b);
    endtask

    task automatic add_s(string s);
        for (int i = 0; i < s.len(); i++)
            id_buf.push_back(s[i]);
    endtask

    task automatic commit_bytes(bit close);
        stim_t s;
        for (int i = 0; i < id_buf.size(); i++)
        begin
            s.b    = id_buf[i];
            s.last = close && (i == id_buf.size() - 1);
            byte_queue.push_back(s);
        end
        bytes_queued += id_buf.size();
        if (close)
            values_queued++;
        id_buf.delete();
    endtask

    task automatic send_id(string s);
        add_s(s);
        commit_bytes(1'b1);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (byte_queue.size() != 0 || in_valid || pending_verdicts.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_mode(bit v);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        utf8_on = v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [7:0] blank_byte();
        return $urandom_range(1) ? CH_SP : CH_TAB;
    endfunction

    function automatic logic [7:0] odd_byte();
        case ($urandom_range(15))
            0:       return CH_DOT;
            1:       return CH_AT;
            2:       return CH_LBR;
            3:       return CH_RBR;
            4:       return CH_BSL;
            5:       return CH_GT;
            6:       return CH_LT;
            7:       return CH_SP;
            8:       return CH_TAB;
            9:       return 8'h80;
            10:      return 8'hC0;
            11:      return 8'hED;
            12:      return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_cont();
        add_b(8'($urandom_range(8'h80, 8'hBF)));
    endtask

    task automatic add_utf8_char();
        case ($urandom_range(6))
            0:
            begin
                add_b(8'($urandom_range(8'hC2, 8'hDF)));
                add_cont();
            end
            1:
            begin
                add_b(8'hE0);
                add_b(8'($urandom_range(8'hA0, 8'hBF)));
                add_cont();
            end
            2:
            begin
                add_b(8'($urandom_range(8'hE1, 8'hEC)));
                add_cont();
                add_cont();
            end
            3:
            begin
                add_b(8'hED);
                add_b(8'($urandom_range(8'h80, 8'h9F)));
                add_cont();
            end
            4:
            begin
                add_b(8'hF0);
                add_b(8'($urandom_range(8'h90, 8'hBF)));
                add_cont();
                add_cont();
            end
            5:
            begin
                add_b(8'($urandom_range(8'hF1, 8'hF3)));
                repeat (3) add_cont();
            end
            default:
            begin
                add_b(8'hF4);
                add_b(8'($urandom_range(8'h80, 8'h8F)));
                add_cont();
                add_cont();
            end
        endcase
    endtask

    task automatic add_atom(int parts);
        for (int p = 0; p < parts; p++)
        begin
            if (p > 0)
                add_b(CH_DOT);
            repeat ($urandom_range(1, 5))
            begin
                if (utf8_on && $urandom_range(7) == 0)
                    add_utf8_char();
                else
                    add_b(ATEXT[$urandom_range(ATEXT.len() - 1)]);
            end
        end
    endtask

    task automatic add_literal();
        logic [7:0] c;
        add_b(CH_LBR);
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(7) == 0)
            begin
                add_b(CH_BSL);
                add_b(8'($urandom_range(PRINT_LO, PRINT_HI)));
            end
            else if (utf8_on && $urandom_range(7) == 0)
                add_utf8_char();
            else
            begin
                c = 8'($urandom_range(PRINT_LO, PRINT_HI));
                if (c == CH_LBR || c == CH_RBR || c == CH_BSL)
                    c = "x";
                add_b(c);
            end
        end
        add_b(CH_RBR);
    endtask

    task automatic make_random_id();
        int r;
        int idx;
        r = $urandom_range(99);
        if (r < 10)
        begin
            if ($urandom_range(1))
                add_b(CH_LT);
            repeat ($urandom_range(1, 8)) add_b(8'($urandom_range(255)));
            commit_bytes(1'b1);
            return;
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) add_b(blank_byte());
        add_b(CH_LT);
        add_atom($urandom_range(1, 3));
        add_b(CH_AT);
        if ($urandom_range(9) < 3)
            add_literal();
        else
            add_atom($urandom_range(1, 3));
        add_b(CH_GT);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) add_b(blank_byte());
        if (r < 40)
        begin
            idx = $urandom_range(id_buf.size() - 1);
            case ($urandom_range(2))
                0:       id_buf[idx] = odd_byte();
                1:       id_buf.delete(idx);
                default: id_buf.insert(idx, odd_byte());
            endcase
        end
        commit_bytes(1'b1);
    endtask

    task automatic random_ids(int n_bytes, int n_ids);
        int b0;
        int v0;
        b0 = bytes_queued;
        v0 = values_queued;
        while (bytes_queued - b0 < n_bytes || values_queued - v0 < n_ids)
            make_random_id();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pace = PACE_RX_HEAVY;
        write_mode(1'b0);
        send_id("<a@b>");
        send_id(" \t<a.b@c.d>\t ");
        send_id("<a@b");
        send_id("a@b>");
        send_id("  x<a@b>");
        send_id("   ");
        send_id("<");
        send_id("<>");
        send_id("<a@>");
        send_id("<ab>");
        send_id("<@b>");
        send_id("<a@b.>");
        send_id("<a..b@c>");
        send_id("<a@b@c>");
        send_id("<a@b>c>");
        send_id("<a@b> >");
        send_id("<a@b     >");
        send_id("<a@b>      ");
        send_id("<a@[1]>");
        send_id("<a@[\\]]>");
        send_id("<a@[]>");
        send_id("<a@[x]y>");
        add_s("<a@[");
        add_b(8'hC3);
        add_s("]>");
        commit_bytes(1'b1);
        add_s("<");
        add_b(8'h80);
        add_s("@b>");
        commit_bytes(1'b1);
        add_b(8'h00);
        commit_bytes(1'b1);
        wait_drained();

        write_mode(1'b1);
        add_s("<");
        add_b(8'hC3);
        add_b(8'hA9);
        add_s("@b>");
        commit_bytes(1'b1);
        add_s("<");
        add_b(8'hC3);
        add_s("@b>");
        commit_bytes(1'b1);
        add_s("<a@");
        add_b(8'hE0);
        add_b(8'h80);
        add_b(8'h80);
        add_s(">");
        commit_bytes(1'b1);
        add_s("<a@");
        add_b(8'hED);
        add_b(8'hA0);
        add_b(8'h80);
        add_s(">");
        commit_bytes(1'b1);
        add_s("<a@");
        add_b(8'hF4);
        add_b(8'h90);
        add_b(8'h80);
        add_b(8'h80);
        add_s(">");
        commit_bytes(1'b1);
        add_s("<a@");
        add_b(8'hF0);
        add_b(8'h90);
        add_b(8'h80);
        add_b(8'h80);
        add_s(">");
        commit_bytes(1'b1);
        add_s("<a@b");
        add_b(8'hC3);
        add_s(">");
        commit_bytes(1'b1);
        add_s("<a@[x");
        add_b(8'hC3);
        add_b(8'hA9);
        add_s("]>");
        commit_bytes(1'b1);
        random_ids(190, 10);
        wait_drained();

        pace = PACE_TX_HEAVY;
        write_mode(1'b0);
        random_ids(190, 10);
        wait_drained();

        pace = PACE_FREE;
        write_mode(1'b1);
        add_s("<");
        add_b(8'hC3);
        add_b(8'hA9);
        commit_bytes(1'b0);
        wait_drained();
        write_mode(1'b0);
        add_s("@b>");
        commit_bytes(1'b1);
        add_s(" <");
        add_b(8'h80);
        commit_bytes(1'b0);
        wait_drained();
        write_mode(1'b1);
        add_s("@b>");
        commit_bytes(1'b1);
        random_ids(190, 10);
        wait_drained();

        repeat (10) @(posedge clk);
        $display("Covered %0d header values (%0d bytes) in both utf8 modes under three pacing",
                 values_queued, bytes_queued);
        $display("profiles; %0d results compared, %0d failures", results_seen, error_count);
        if (error_count == 0 && pending_verdicts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
